FILE: src/rna_pkg.sv
// ----------------------------------------------------------------------------
// rna_pkg: shared definitions for the rational number ALU
// Operation codes, widths and the handshake between the control FSM and the
// serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

package rna_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int WORD_WIDTH    = 64;
    localparam int CNT_WIDTH     = 7;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_SIM = 3'd4;

    // request to the serial divider
    typedef struct packed {
        logic                          start;
        logic signed [WORD_WIDTH-1:0]  dividend;
        logic signed [WORD_WIDTH-1:0]  divisor;
    } div_req_t;

    // answer from the serial divider
    typedef struct packed {
        logic                          done;
        logic signed [WORD_WIDTH-1:0]  quotient;
        logic signed [WORD_WIDTH-1:0]  remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

FILE: src/rna_div.sv
// ----------------------------------------------------------------------------
// rna_div: bit-serial signed divider
// Restoring division of magnitudes, one quotient bit per cycle, with C
// truncation rules; zero divisor gives quotient 0 and remainder = dividend.
// ----------------------------------------------------------------------------
`default_nettype none

module rna_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rna_pkg::div_req_t req,
    output rna_pkg::div_rsp_t      rsp
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIX} state_t;

    state_t                                state_reg;
    logic [rna_pkg::CNT_WIDTH-1:0]         cnt_reg;
    logic [rna_pkg::WORD_WIDTH-1:0]        quo_reg;
    logic [rna_pkg::WORD_WIDTH-1:0]        rem_reg;
    logic [rna_pkg::WORD_WIDTH-1:0]        dvs_reg;
    logic [rna_pkg::WORD_WIDTH-1:0]        dvd_reg;
    logic                                  qneg_reg;
    logic                                  rneg_reg;
    logic                                  zero_reg;
    logic                                  done_reg;

    logic [rna_pkg::WORD_WIDTH:0]          trial;
    logic [rna_pkg::WORD_WIDTH:0]          diff;

    // one shift-subtract step
    always_comb
    begin
        trial = {rem_reg, quo_reg[rna_pkg::WORD_WIDTH-1]};
        diff  = trial - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (req.start)
                    begin
                        quo_reg   <= req.dividend[rna_pkg::WORD_WIDTH-1] ?
                                     (~req.dividend + 1'b1) : req.dividend;
                        dvs_reg   <= req.divisor[rna_pkg::WORD_WIDTH-1] ?
                                     (~req.divisor + 1'b1) : req.divisor;
                        dvd_reg   <= req.dividend;
                        rem_reg   <= '0;
                        qneg_reg  <= req.dividend[rna_pkg::WORD_WIDTH-1] ^
                                     req.divisor[rna_pkg::WORD_WIDTH-1];
                        rneg_reg  <= req.dividend[rna_pkg::WORD_WIDTH-1];
                        zero_reg  <= (req.divisor == '0);
                        cnt_reg   <= '0;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    quo_reg <= {quo_reg[rna_pkg::WORD_WIDTH-2:0], ~diff[rna_pkg::WORD_WIDTH]};
                    rem_reg <= diff[rna_pkg::WORD_WIDTH] ?
                               trial[rna_pkg::WORD_WIDTH-1:0] : diff[rna_pkg::WORD_WIDTH-1:0];
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == rna_pkg::CNT_WIDTH'(rna_pkg::WORD_WIDTH - 1))
                        state_reg <= S_FIX;
                end
                S_FIX:
                begin
                    // apply signs; magnitudes wrap like two's complement
                    if (zero_reg)
                    begin
                        quo_reg <= '0;
                        rem_reg <= dvd_reg;
                    end
                    else
                    begin
                        if (qneg_reg)
                            quo_reg <= ~quo_reg + 1'b1;
                        if (rneg_reg)
                            rem_reg <= ~rem_reg + 1'b1;
                    end
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

FILE: src/rna_mul.sv
// ----------------------------------------------------------------------------
// rna_mul: bit-serial 64x64 multiplier, low 64 bits of the product
// Shift-and-add, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rna_mul (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [rna_pkg::WORD_WIDTH-1:0]  op_a,
    input  wire logic [rna_pkg::WORD_WIDTH-1:0]  op_b,
    output logic                                 done,
    output logic [rna_pkg::WORD_WIDTH-1:0]       product
);

    logic                                  busy_reg;
    logic                                  done_reg;
    logic [rna_pkg::CNT_WIDTH-1:0]         cnt_reg;
    logic [rna_pkg::WORD_WIDTH-1:0]        mcd_reg;
    logic [rna_pkg::WORD_WIDTH-1:0]        mpr_reg;
    logic [rna_pkg::WORD_WIDTH-1:0]        acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg)
            begin
                if (start)
                begin
                    mcd_reg  <= op_a;
                    mpr_reg  <= op_b;
                    acc_reg  <= '0;
                    cnt_reg  <= '0;
                    busy_reg <= 1'b1;
                end
            end
            else
            begin
                if (mpr_reg[0])
                    acc_reg <= acc_reg + mcd_reg;
                mcd_reg <= {mcd_reg[rna_pkg::WORD_WIDTH-2:0], 1'b0};
                mpr_reg <= {1'b0, mpr_reg[rna_pkg::WORD_WIDTH-1:1]};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == rna_pkg::CNT_WIDTH'(rna_pkg::WORD_WIDTH - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

FILE: src/rational_number_alu.sv
// ----------------------------------------------------------------------------
// rational_number_alu: arithmetic on two signed fractions
// Add, subtract (lcm scaling and gcd reduction), multiply, divide, simplify.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid/in_stall with cmd and four 32-bit operands.
//   Output channel: out_valid/out_stall with 64-bit numerator, denominator
//   and the bad_operand flag. One result beat per input beat.
//   One beat is worked at a time, in a bit-serial multiplier and a
//   bit-serial divider; each Euclid step is one division. Add and subtract
//   take two gcds, five further divisions and three products; multiply
//   and divide take two products; simplify takes one gcd and two
//   divisions. Invalid operands go straight from decode to the result.
//   The result sits in an output register; a new beat is taken while it
//   waits to be taken, but its result is held back until the register
//   frees. Stall on the output holds the result stable.
//   Reset clears all control state; no beat is pending afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_number_alu (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    in_valid,
    output logic                                         in_stall,
    input  wire logic [2:0]                              cmd,
    input  wire logic signed [rna_pkg::OPERAND_WIDTH-1:0] a_numerator,
    input  wire logic signed [rna_pkg::OPERAND_WIDTH-1:0] a_denominator,
    input  wire logic signed [rna_pkg::OPERAND_WIDTH-1:0] b_numerator,
    input  wire logic signed [rna_pkg::OPERAND_WIDTH-1:0] b_denominator,
    output logic                                         out_valid,
    input  wire logic                                    out_stall,
    output logic signed [rna_pkg::WORD_WIDTH-1:0]        res_numerator,
    output logic signed [rna_pkg::WORD_WIDTH-1:0]        res_denominator,
    output logic                                         bad_operand
);

    localparam int W = rna_pkg::WORD_WIDTH;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE,
        S_G1_DIV, S_G1_WAIT,          // gcd(ad, bd)
        S_L_MUL, S_L_MWAIT,           // ad*bd
        S_L_DIV, S_L_DWAIT,           // lcm = prod / g
        S_P_DIV, S_P_DWAIT, S_P_MUL, S_P_MWAIT,
        S_Q_DIV, S_Q_DWAIT, S_Q_MUL, S_Q_MWAIT,
        S_COMB,
        S_G2_DIV, S_G2_WAIT,          // gcd(n, d) or gcd(an, ad)
        S_R1_DIV, S_R1_WAIT, S_R2_DIV, S_R2_WAIT,
        S_M1, S_M1_WAIT, S_M2, S_M2_WAIT,
        S_DONE
    } state_t;

    state_t                state_reg;
    logic [2:0]            cmd_reg;
    logic signed [W-1:0]   an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [W-1:0]   x_reg, y_reg;       // Euclid pair
    logic signed [W-1:0]   d_reg, n_reg, p_reg, t_reg;
    logic signed [W-1:0]   rn_reg, rd_reg;
    logic                  bad_reg;
    logic                  busy_reg;
    logic                  ovalid_reg;
    logic                  ovalid_next;
    logic signed [W-1:0]   onum_reg, oden_reg;
    logic                  obad_reg;

    rna_pkg::div_req_t     dreq;
    rna_pkg::div_rsp_t     drsp;
    logic                  mstart;
    logic [W-1:0]          ma, mb;
    logic                  mdone;
    logic [W-1:0]          mprod;

    rna_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    rna_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mstart),
        .op_a    (ma),
        .op_b    (mb),
        .done    (mdone),
        .product (mprod)
    );

    // divider and multiplier launches per state
    always_comb
    begin
        dreq.start    = 1'b0;
        dreq.dividend = x_reg;
        dreq.divisor  = y_reg;
        mstart        = 1'b0;
        ma            = an_reg;
        mb            = bn_reg;
        case (state_reg)
            S_G1_DIV, S_G2_DIV: dreq.start = (y_reg != '0);
            S_L_DIV:
            begin
                dreq.start = 1'b1; dreq.dividend = t_reg; dreq.divisor = d_reg;
            end
            S_P_DIV:
            begin
                dreq.start = 1'b1; dreq.dividend = d_reg; dreq.divisor = ad_reg;
            end
            S_Q_DIV:
            begin
                dreq.start = 1'b1; dreq.dividend = d_reg; dreq.divisor = bd_reg;
            end
            S_R1_DIV:
            begin
                dreq.start = 1'b1; dreq.dividend = n_reg; dreq.divisor = x_reg;
            end
            S_R2_DIV:
            begin
                dreq.start = 1'b1; dreq.dividend = d_reg; dreq.divisor = x_reg;
            end
            S_L_MUL:
            begin
                mstart = 1'b1; ma = ad_reg; mb = bd_reg;
            end
            S_P_MUL:
            begin
                mstart = 1'b1; ma = an_reg; mb = t_reg;
            end
            S_Q_MUL:
            begin
                mstart = 1'b1; ma = bn_reg; mb = t_reg;
            end
            S_M1:
            begin
                mstart = 1'b1;
                ma = an_reg;
                mb = (cmd_reg == rna_pkg::CMD_MUL) ? bn_reg : bd_reg;
            end
            S_M2:
            begin
                mstart = 1'b1;
                ma = ad_reg;
                mb = (cmd_reg == rna_pkg::CMD_MUL) ? bd_reg : bn_reg;
            end
            default: ;
        endcase
    end

    // output valid: cleared when taken, set when a result is loaded
    always_comb
    begin
        ovalid_next = ovalid_reg && out_stall;
        if (state_reg == S_DONE && (!ovalid_reg || !out_stall))
            ovalid_next = 1'b1;
    end

    assign in_stall = busy_reg;

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !busy_reg)
                    begin
                        cmd_reg   <= cmd;
                        an_reg    <= W'(a_numerator);
                        ad_reg    <= W'(a_denominator);
                        bn_reg    <= W'(b_numerator);
                        bd_reg    <= W'(b_denominator);
                        busy_reg  <= 1'b1;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    rn_reg  <= an_reg;
                    rd_reg  <= ad_reg;
                    bad_reg <= 1'b0;
                    if (cmd_reg <= rna_pkg::CMD_DIV && (ad_reg == '0 || bd_reg == '0))
                    begin
                        bad_reg   <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        case (cmd_reg)
                            rna_pkg::CMD_ADD, rna_pkg::CMD_SUB:
                            begin
                                x_reg     <= ad_reg;
                                y_reg     <= bd_reg;
                                state_reg <= S_G1_DIV;
                            end
                            rna_pkg::CMD_MUL, rna_pkg::CMD_DIV: state_reg <= S_M1;
                            rna_pkg::CMD_SIM:
                            begin
                                x_reg     <= an_reg;
                                y_reg     <= ad_reg;
                                n_reg     <= an_reg;
                                d_reg     <= ad_reg;
                                state_reg <= S_G2_DIV;
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                // Euclid: one remainder per step
                S_G1_DIV: state_reg <= (y_reg == '0) ? S_L_MUL : S_G1_WAIT;
                S_G1_WAIT:
                begin
                    if (drsp.done)
                    begin
                        x_reg     <= y_reg;
                        y_reg     <= (y_reg == -64'sd1) ? '0 : drsp.remainder;
                        state_reg <= S_G1_DIV;
                    end
                end
                S_L_MUL: state_reg <= S_L_MWAIT;
                S_L_MWAIT:
                begin
                    if (mdone)
                    begin
                        t_reg     <= mprod;
                        d_reg     <= x_reg;
                        state_reg <= S_L_DIV;
                    end
                end
                S_L_DIV: state_reg <= S_L_DWAIT;
                S_L_DWAIT:
                begin
                    if (drsp.done)
                    begin
                        d_reg     <= (d_reg == -64'sd1) ? -t_reg : drsp.quotient;
                        state_reg <= S_P_DIV;
                    end
                end
                S_P_DIV: state_reg <= S_P_DWAIT;
                S_P_DWAIT:
                begin
                    if (drsp.done)
                    begin
                        t_reg     <= (ad_reg == -64'sd1) ? -d_reg : drsp.quotient;
                        state_reg <= S_P_MUL;
                    end
                end
                S_P_MUL: state_reg <= S_P_MWAIT;
                S_P_MWAIT:
                begin
                    if (mdone)
                    begin
                        p_reg     <= mprod;
                        state_reg <= S_Q_DIV;
                    end
                end
                S_Q_DIV: state_reg <= S_Q_DWAIT;
                S_Q_DWAIT:
                begin
                    if (drsp.done)
                    begin
                        t_reg     <= (bd_reg == -64'sd1) ? -d_reg : drsp.quotient;
                        state_reg <= S_Q_MUL;
                    end
                end
                S_Q_MUL: state_reg <= S_Q_MWAIT;
                S_Q_MWAIT:
                begin
                    if (mdone)
                    begin
                        n_reg     <= (cmd_reg == rna_pkg::CMD_ADD) ? p_reg + mprod
                                                                   : p_reg - mprod;
                        x_reg     <= (cmd_reg == rna_pkg::CMD_ADD) ? p_reg + mprod
                                                                   : p_reg - mprod;
                        y_reg     <= d_reg;
                        state_reg <= S_G2_DIV;
                    end
                end
                S_COMB: state_reg <= S_G2_DIV;
                S_G2_DIV:
                begin
                    if (y_reg == '0)
                    begin
                        // gcd zero only for simplify of 0/0: keep a
                        if (x_reg == '0)
                            state_reg <= S_DONE;
                        else
                            state_reg <= S_R1_DIV;
                    end
                    else
                        state_reg <= S_G2_WAIT;
                end
                S_G2_WAIT:
                begin
                    if (drsp.done)
                    begin
                        x_reg     <= y_reg;
                        y_reg     <= (y_reg == -64'sd1) ? '0 : drsp.remainder;
                        state_reg <= S_G2_DIV;
                    end
                end
                S_R1_DIV: state_reg <= S_R1_WAIT;
                S_R1_WAIT:
                begin
                    if (drsp.done)
                    begin
                        rn_reg    <= (x_reg == -64'sd1) ? -n_reg : drsp.quotient;
                        state_reg <= S_R2_DIV;
                    end
                end
                S_R2_DIV: state_reg <= S_R2_WAIT;
                S_R2_WAIT:
                begin
                    if (drsp.done)
                    begin
                        rd_reg    <= (x_reg == -64'sd1) ? -d_reg : drsp.quotient;
                        state_reg <= S_DONE;
                    end
                end
                S_M1: state_reg <= S_M1_WAIT;
                S_M1_WAIT:
                begin
                    if (mdone)
                    begin
                        rn_reg    <= mprod;
                        state_reg <= S_M2;
                    end
                end
                S_M2: state_reg <= S_M2_WAIT;
                S_M2_WAIT:
                begin
                    if (mdone)
                    begin
                        if (cmd_reg == rna_pkg::CMD_DIV && mprod == '0)
                        begin
                            rn_reg <= 64'sd1;
                            rd_reg <= '0;
                        end
                        else
                            rd_reg <= mprod;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!ovalid_reg || !out_stall)
                    begin
                        onum_reg   <= rn_reg;
                        oden_reg   <= rd_reg;
                        obad_reg   <= bad_reg;
                        busy_reg   <= 1'b0;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid       = ovalid_reg;
    assign res_numerator   = onum_reg;
    assign res_denominator = oden_reg;
    assign bad_operand     = obad_reg;

endmodule

`default_nettype wire
